FILE: rtl/core/hrss_pkg.sv
// Package for the height reference source switch.
// Holds the request and result types, the barometer phase codes and the
// 26-bit saturation helper; it depends on nothing else.
package hrss_pkg;

    localparam int HEIGHT_W = 26;
    localparam int SUM_W    = 28;
    localparam int CM_W     = 20;

    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_ARMED  = 2'd1;
    localparam logic [1:0] PHASE_FLIGHT = 2'd2;

    typedef logic signed [HEIGHT_W-1:0] t_height;
    typedef logic signed [SUM_W-1:0]    t_sum;

    typedef struct packed {
        logic                   in_flight;
        logic                   imu_ok;
        logic                   tof_hardware_ok;
        logic                   flow_hardware_ok;
        logic                   tof_range_valid;
        logic                   flow_range_valid;
        logic signed [CM_W-1:0] baro_cm;
        logic signed [CM_W-1:0] range_height;
    } t_in_item;

    typedef struct packed {
        t_height reference_height;
        logic    using_range;
    } t_out_item;

    function automatic t_sum ext_cm(input logic signed [CM_W-1:0] v);
        ext_cm = {{(SUM_W-CM_W-4){v[CM_W-1]}}, v, 4'b0000};
    endfunction

    function automatic t_sum ext_h(input t_height v);
        ext_h = {{(SUM_W-HEIGHT_W){v[HEIGHT_W-1]}}, v};
    endfunction

    function automatic t_height sat26(input t_sum v);
        if (v[SUM_W-1:HEIGHT_W-1] == '0 || v[SUM_W-1:HEIGHT_W-1] == '1) begin
            sat26 = v[HEIGHT_W-1:0];
        end else if (v[SUM_W-1]) begin
            sat26 = {1'b1, {(HEIGHT_W-1){1'b0}}};
        end else begin
            sat26 = {1'b0, {(HEIGHT_W-1){1'b1}}};
        end
    endfunction

endpackage

FILE: rtl/core/hrss_core.sv
// State and per-request update of the height reference source switch.
// Uses hrss_pkg for types, phase codes and saturation; instantiated by the
// top level, which owns the handshake registers.
module hrss_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  hrss_pkg::t_in_item  i_item,
    output hrss_pkg::t_out_item o_result
);

    logic [1:0]       r_phase, n_phase;
    logic             r_locked, n_locked;
    hrss_pkg::t_height r_base, n_base;
    hrss_pkg::t_height r_r2b, n_r2b;
    hrss_pkg::t_height r_b2r, n_b2r;
    hrss_pkg::t_height r_bref, n_bref;
    hrss_pkg::t_height r_held, n_held;
    logic             n_follow;

    logic             hw_ok;
    logic             rng_ok;
    hrss_pkg::t_sum   baro16;
    hrss_pkg::t_sum   range16;
    hrss_pkg::t_height ref2;
    hrss_pkg::t_sum   diff;

    assign hw_ok  = i_item.tof_hardware_ok | i_item.flow_hardware_ok;
    assign rng_ok = i_item.tof_range_valid | i_item.flow_range_valid;
    assign baro16  = hrss_pkg::ext_cm(i_item.baro_cm);
    assign range16 = hrss_pkg::ext_cm(i_item.range_height);

    always_comb begin
        n_phase  = r_phase;
        n_locked = r_locked;
        n_base   = r_base;
        n_r2b    = r_r2b;
        n_b2r    = r_b2r;
        n_bref   = r_bref;
        n_held   = r_held;
        n_follow = 1'b0;
        ref2     = '0;
        diff     = '0;

        if (i_item.in_flight) begin
            n_phase = hrss_pkg::PHASE_FLIGHT;
        end else begin
            if (r_phase == hrss_pkg::PHASE_FLIGHT) begin
                n_phase = hrss_pkg::PHASE_IDLE;
            end
            n_r2b = '0;
        end

        if (n_phase != hrss_pkg::PHASE_IDLE) begin
            n_bref = hrss_pkg::sat26(baro16 - hrss_pkg::ext_h(r_base)
                                     + hrss_pkg::ext_h(n_r2b));
        end else begin
            n_base = baro16[hrss_pkg::HEIGHT_W-1:0];
            if (i_item.imu_ok) begin
                n_phase = hrss_pkg::PHASE_ARMED;
            end
        end

        if (hw_ok && n_phase != hrss_pkg::PHASE_IDLE) begin
            if (rng_ok) begin
                if (r_locked) begin
                    ref2 = hrss_pkg::sat26(range16 + hrss_pkg::ext_h(r_b2r));
                    diff = hrss_pkg::ext_h(hrss_pkg::sat26(hrss_pkg::ext_h(ref2)
                                                           - hrss_pkg::ext_h(n_bref)))
                           - hrss_pkg::ext_h(n_r2b);
                    n_held   = ref2;
                    n_follow = 1'b1;
                    n_r2b    = hrss_pkg::sat26(hrss_pkg::ext_h(n_r2b) + (diff >>> 1));
                end else begin
                    n_b2r    = hrss_pkg::sat26(hrss_pkg::ext_h(n_bref) - range16);
                    n_locked = 1'b1;
                end
            end else begin
                n_locked = 1'b0;
                n_held   = n_bref;
            end
        end else begin
            n_held = n_bref;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= hrss_pkg::PHASE_IDLE;
            r_locked <= 1'b0;
            r_base   <= '0;
            r_r2b    <= '0;
            r_b2r    <= '0;
            r_bref   <= '0;
            r_held   <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_locked <= n_locked;
            r_base   <= n_base;
            r_r2b    <= n_r2b;
            r_b2r    <= n_b2r;
            r_bref   <= n_bref;
            r_held   <= n_held;
        end
    end

    assign o_result.reference_height = n_held;
    assign o_result.using_range      = n_follow;

`ifndef SYNTHESIS
    a_follow_needs_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_result.using_range) |-> r_locked)
        else $error("Range followed without a latched offset.");

    a_ground_clears_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && !i_item.in_flight && !hw_ok) |=> (r_r2b == '0))
        else $error("Range-to-baro offset kept on the ground.");

    a_flight_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.in_flight) |=> (r_phase == hrss_pkg::PHASE_FLIGHT))
        else $error("Flight request did not enter the flight phase.");
`endif

endmodule

FILE: rtl/core/height_reference_source_switch.sv
// A request accepted into the input register passes through the core into the
// result register that drives o_data; i_stall can keep it in the input register.
// Throughput: one request per cycle unless i_stall holds the result; the state
// update is a single pass of adders and saturation between input and result regs.
// Reset (i_rst_n low, synchronous) empties both registers and clears every
// height, offset, lock and phase register to zero.
module height_reference_source_switch (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  hrss_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output hrss_pkg::t_out_item o_data
);

    logic               r_in_valid;
    hrss_pkg::t_in_item  r_in;
    logic               r_out_valid;
    hrss_pkg::t_out_item r_out;
    hrss_pkg::t_out_item result;
    logic               advance;
    logic               step;

    assign advance = !r_out_valid || !i_stall;
    assign step    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_data;
        end
    end

    hrss_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid after reset.");

    a_step_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_valid)
        else $error("Processed request produced no result.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && o_valid && i_stall))
        else $error("Input stalled without a blocked result.");
`endif

endmodule

FILE: bench/height_reference_source_switch_tb.sv
// Self-checking testbench for height_reference_source_switch: directed and random requests.
// A local fixed-point model predicts every result, with random idling on both sides.
// Depends on hrss_pkg and the height_reference_source_switch RTL only.
module height_reference_source_switch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;
    localparam longint H_MAX = 64'sd33554431;
    localparam longint H_MIN = -64'sd33554432;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    hrss_pkg::t_in_item  i_data;
    logic                o_valid;
    logic                i_stall;
    hrss_pkg::t_out_item o_data;

    hrss_pkg::t_out_item expected_heights[$];
    int        errors = 0;
    int        idle_count = 0;
    bit        drv_idle_on = 1'b0;
    bit        stall_on = 1'b0;

    logic [1:0] est_phase = hrss_pkg::PHASE_IDLE;
    bit         est_locked = 1'b0;
    longint     est_base = 0;
    longint     est_r2b = 0;
    longint     est_b2r = 0;
    longint     est_baro_ref = 0;
    longint     est_held = 0;

    height_reference_source_switch u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint clamp_height(input longint v);
        if (v > H_MAX) begin
            return H_MAX;
        end else if (v < H_MIN) begin
            return H_MIN;
        end
        return v;
    endfunction

    function automatic hrss_pkg::t_out_item compute_reference(input hrss_pkg::t_in_item req);
        longint              baro_fx;
        longint              rng_fx;
        longint              follow_ref;
        longint              diff;
        bit                  hw;
        bit                  vld;
        bit                  follow;
        hrss_pkg::t_out_item res;
        hw      = req.tof_hardware_ok | req.flow_hardware_ok;
        vld     = req.tof_range_valid | req.flow_range_valid;
        baro_fx = longint'($signed(req.baro_cm)) * 16;
        rng_fx  = longint'($signed(req.range_height)) * 16;
        follow  = 1'b0;

        if (req.in_flight) begin
            est_phase = hrss_pkg::PHASE_FLIGHT;
        end else begin
            if (est_phase == hrss_pkg::PHASE_FLIGHT) begin
                est_phase = hrss_pkg::PHASE_IDLE;
            end
            est_r2b = 0;
        end

        if (est_phase != hrss_pkg::PHASE_IDLE) begin
            est_baro_ref = clamp_height(baro_fx - est_base + est_r2b);
        end else begin
            est_base = baro_fx;
            if (req.imu_ok) begin
                est_phase = hrss_pkg::PHASE_ARMED;
            end
        end

        if (hw && est_phase != hrss_pkg::PHASE_IDLE) begin
            if (vld) begin
                if (est_locked) begin
                    follow_ref = clamp_height(rng_fx + est_b2r);
                    diff       = clamp_height(follow_ref - est_baro_ref) - est_r2b;
                    est_held   = follow_ref;
                    follow     = 1'b1;
                    est_r2b    = clamp_height(est_r2b + (diff >>> 1));
                end else begin
                    est_b2r    = clamp_height(est_baro_ref - rng_fx);
                    est_locked = 1'b1;
                end
            end else begin
                est_locked = 1'b0;
                est_held   = est_baro_ref;
            end
        end else begin
            est_held = est_baro_ref;
        end

        res.reference_height = est_held[hrss_pkg::HEIGHT_W-1:0];
        res.using_range      = follow;
        return res;
    endfunction

    function automatic hrss_pkg::t_in_item make_req(input bit [5:0] flags, input int baro,
                                                    input int rng);
        return {flags, baro[19:0], rng[19:0]};
    endfunction

    function automatic int clip_cm(input int v);
        if (v > 524287) begin
            return 524287;
        end else if (v < -524288) begin
            return -524288;
        end
        return v;
    endfunction

    function automatic int pick_cm();
        case ($urandom_range(0, 9))
            0: return 524287;
            1: return -524288;
            2: return 0;
            3, 4: return int'($urandom_range(0, 1048575)) - 524288;
            default: return int'($urandom_range(0, 4000)) - 2000;
        endcase
    endfunction

    task automatic send_request(input hrss_pkg::t_in_item req);
        if (drv_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        expected_heights.push_back(compute_reference(req));
    endtask

    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        hrss_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_heights.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, o_data);
            end else begin
                want = expected_heights.pop_front();
                if (o_data.reference_height !== want.reference_height) begin
                    errors++;
                    $display("%0t: reference_height expected %0d actual %0d", $time,
                             want.reference_height, o_data.reference_height);
                end
                if (o_data.using_range !== want.using_range) begin
                    errors++;
                    $display("%0t: using_range expected %0b actual %0b", $time,
                             want.using_range, o_data.using_range);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_count <= 0;
            end else if (idle_count >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_count <= idle_count + 1;
            end
        end
    end

    task automatic test_ground_capture();
        send_request(make_req(6'b001111, 524287, 0));
        send_request(make_req(6'b000000, -524288, -524288));
        send_request(make_req(6'b011010, 1000, 500));
    endtask

    task automatic test_armed_baro();
        send_request(make_req(6'b000000, 524287, 0));
        send_request(make_req(6'b000000, -524288, 12));
    endtask

    task automatic test_range_lock();
        send_request(make_req(6'b001010, 2000, 300));
        send_request(make_req(6'b000101, 2100, 524287));
        send_request(make_req(6'b001111, 2100, -524288));
        send_request(make_req(6'b000011, 2150, 400));
        send_request(make_req(6'b001001, 2150, 410));
        send_request(make_req(6'b000100, 2200, 420));
        send_request(make_req(6'b000110, 2200, 430));
    endtask

    task automatic test_flight_cycle();
        send_request(make_req(6'b101110, 2300, 500));
        send_request(make_req(6'b111111, 524287, 524287));
        send_request(make_req(6'b101010, -524288, -524288));
        send_request(make_req(6'b001111, 100, 100));
        send_request(make_req(6'b001111, 200, 100));
        send_request(make_req(6'b101111, 300, 100));
    endtask

    task automatic test_saturation();
        send_request(make_req(6'b010000, -524288, 0));
        send_request(make_req(6'b101010, 524287, -524288));
        send_request(make_req(6'b101000, 524287, 0));
        send_request(make_req(6'b101010, 524287, -524288));
        send_request(make_req(6'b101010, 524287, 524287));
        send_request(make_req(6'b101010, 524287, 524287));
        send_request(make_req(6'b100000, 524287, 0));
    endtask

    task automatic test_random_flights(input int count, input bit quiet);
        int                 ground;
        int                 alt;
        int                 len;
        int                 k;
        bit                 in_range;
        bit [1:0]           hw_bits;
        bit [1:0]           vld_bits;
        logic [63:0]        rnd;
        hrss_pkg::t_in_item req;
        while (count > 0) begin
            drv_idle_on = !quiet && ($urandom_range(0, 3) != 0);
            stall_on    = !quiet && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0) begin
                len = $urandom_range(1, 10);
                for (k = 0; k < len; k++) begin
                    rnd = {$urandom(), $urandom()};
                    req = rnd[$bits(hrss_pkg::t_in_item)-1:0];
                    send_request(req);
                    count--;
                end
            end else begin
                ground = pick_cm();
                len    = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    rnd = $urandom();
                    send_request(make_req({1'b0, (k == len - 1) | rnd[0], rnd[4:1]},
                                          clip_cm(ground + int'($urandom_range(0, 20)) - 10),
                                          pick_cm()));
                    count--;
                end
                alt      = 0;
                in_range = 1'b1;
                len      = $urandom_range(10, 60);
                for (k = 0; k < len; k++) begin
                    alt = clip_cm(alt + int'($urandom_range(0, 100)) - 50);
                    if ($urandom_range(0, 7) == 0) begin
                        in_range = !in_range;
                    end
                    hw_bits  = ($urandom_range(0, 9) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
                    vld_bits = in_range ? 2'($urandom_range(1, 3)) : 2'b00;
                    req = make_req({1'b1, 1'($urandom_range(0, 1)), hw_bits, vld_bits},
                                   clip_cm(ground + alt + int'($urandom_range(0, 40)) - 20),
                                   ($urandom_range(0, 19) == 0) ? pick_cm()
                                       : clip_cm(alt + int'($urandom_range(0, 10)) - 5));
                    send_request(req);
                    count--;
                end
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++) begin
                    rnd = $urandom();
                    send_request(make_req({2'b00, rnd[3:0]}, clip_cm(ground + alt), alt));
                    count--;
                end
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drv_idle_on = 1'b1;
        stall_on    = 1'b1;

        test_ground_capture();
        test_armed_baro();
        test_range_lock();
        test_flight_cycle();
        test_saturation();
        test_random_flights(1175, 1'b0);
        test_random_flights(200, 1'b1);

        i_valid <= 1'b0;
        while (expected_heights.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
